[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on the rising clock edge, off while reset is held.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/aspd_pkg.sv]
// Package: types, codes and constants of the airspeed Kalman unit.
`timescale 1ns / 1ps
package aspd_pkg;

  localparam int unsigned SUB_W      = 34;
  localparam int unsigned SQRT_STEPS = 26;
  localparam int unsigned DIV_STEPS  = 24;
  localparam int unsigned CNT_W      = 5;

  localparam logic [31:0] PROC_NOISE_RST = 32'd838861;
  localparam logic [31:0] MEAS_NOISE_RST = 32'd6710886;
  localparam logic [27:0] TWO_DENS_RST   = 28'd27391372;
  localparam logic [23:0] CLAMP_SPEED    = 24'd2648;

  typedef enum logic [1:0] {
    REQ_MEASURE  = 2'd0,
    REQ_CAL_INIT = 2'd1,
    REQ_CAL_NEXT = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_PROC_NOISE = 2'd0,
    CFG_MEAS_NOISE = 2'd1,
    CFG_TWO_DENS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DP,
    ST_SQRT,
    ST_PMID,
    ST_DIV,
    ST_MUL_E,
    ST_MUL_G,
    ST_MUL_P,
    ST_COV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             ge;
    logic [SUB_W-1:0] diff;
  } sub_res_t;

endpackage

[design/aspd_sub_unit.sv]
// Shared compare-and-subtract unit for the square root and divider steps.
`timescale 1ns / 1ps
module aspd_sub_unit
  import aspd_pkg::*;
(
  input  logic [SUB_W-1:0] a_i,
  input  logic [SUB_W-1:0] b_i,
  output sub_res_t         res_o
);

  logic [SUB_W:0] diff_full;

  assign diff_full  = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~diff_full[SUB_W];
  assign res_o.diff = diff_full[SUB_W-1:0];

endmodule

[design/airspeed_from_diff_pressure_kalman_unit.sv]
// Top level: pitot airspeed with zero offset and scalar Kalman smoothing.
// Calibrate item goes straight to result; measure item with a positive difference:
//   multiply, 26-step square root, 24-step gain divider on one shared subtractor, then
//   estimate and covariance update; no root otherwise, no divider on a zero divisor.
// Throughput: one item at a time; next item taken the cycle after the result leaves.
// Reset: async active low; offset, estimate, covariance cleared, noise/density defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module airspeed_from_diff_pressure_kalman_unit
  import aspd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] raw_pressure
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [23:0] ias_unfiltered, [47:24] ias_filtered,
                                      // [71:48] offset_now
  output logic [0:0]  m_axis_tuser,   // [0] below_zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [31:0] proc_noise_q, meas_noise_q;
  logic [27:0] two_dens_q;

  logic [23:0] offset_q, offset_d;
  logic [23:0] est_q, est_d;
  logic [31:0] cov_q, cov_d;
  logic [23:0] ias_q, ias_d;
  logic        below_q, below_d;
  logic [23:0] dp_q, dp_d;
  logic [59:0] prod_q, prod_d;
  logic [47:0] acc_q, acc_d;
  logic [25:0] root_q, root_d;
  logic [26:0] rem_q, rem_d;
  logic [32:0] r_q, r_d;
  logic [31:0] pmid_q, pmid_d;
  logic [32:0] den_q, den_d;
  logic [24:0] gain_q, gain_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [24:0] raw_ext, off_ext, dp_c, cal_sum;
  logic [32:0] cov_q_sum, den_c;
  logic [31:0] pmid_c;
  logic [24:0] keep;
  logic [28:0] rem_sh;
  logic [25:0] root_step;
  logic [48:0] est_sum;
  logic [55:0] cov_sum;
  logic [31:0] mul_a;
  logic [27:0] mul_b;
  logic [59:0] mul_p;
  logic [SUB_W-1:0] sub_a, sub_b;
  sub_res_t    sub_res;
  req_e        req;

  aspd_sub_unit u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  assign req       = req_e'(s_axis_tuser);
  assign raw_ext   = {s_axis_tdata[23], s_axis_tdata};
  assign off_ext   = {offset_q[23], offset_q};
  assign dp_c      = raw_ext - off_ext;
  assign cal_sum   = raw_ext + off_ext;
  assign cov_q_sum = {1'b0, cov_q} + {1'b0, proc_noise_q};
  assign pmid_c    = cov_q_sum[32] ? 32'hFFFF_FFFF : cov_q_sum[31:0];
  assign den_c     = {1'b0, pmid_c} + {1'b0, meas_noise_q};
  assign keep      = 25'h100_0000 - gain_q;
  assign rem_sh    = {rem_q, prod_q[51:50]};
  assign root_step = {root_q[24:0], sub_res.ge};
  assign mul_p     = {28'd0, mul_a} * {32'd0, mul_b};
  assign est_sum   = {1'b0, acc_q} + {1'b0, prod_q[47:0]} + 49'h80_0000;
  assign cov_sum   = prod_q[55:0] + 56'h80_0000;

  always_comb begin
    state_d  = state_q;
    offset_d = offset_q;
    est_d    = est_q;
    cov_d    = cov_q;
    ias_d    = ias_q;
    below_d  = below_q;
    dp_d     = dp_q;
    prod_d   = prod_q;
    acc_d    = acc_q;
    root_d   = root_q;
    rem_d    = rem_q;
    r_d      = r_q;
    pmid_d   = pmid_q;
    den_d    = den_q;
    gain_d   = gain_q;
    cnt_d    = cnt_q;
    mul_a    = '0;
    mul_b    = '0;
    sub_a    = '0;
    sub_b    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ias_d   = '0;
          below_d = 1'b0;
          state_d = ST_OUT;
          case (req)
            REQ_MEASURE: begin
              if (dp_c[24]) begin
                below_d = 1'b1;
                ias_d   = CLAMP_SPEED;
                state_d = ST_PMID;
              end else if (dp_c == '0) begin
                state_d = ST_PMID;
              end else begin
                dp_d    = dp_c[23:0];
                state_d = ST_MUL_DP;
              end
            end
            REQ_CAL_INIT: offset_d = s_axis_tdata;
            REQ_CAL_NEXT: offset_d = cal_sum[24:1];
            default: ;
          endcase
        end
      end
      ST_MUL_DP: begin
        mul_a   = {8'd0, dp_q};
        mul_b   = two_dens_q;
        prod_d  = mul_p;
        root_d  = '0;
        rem_d   = '0;
        cnt_d   = CNT_W'(SQRT_STEPS - 1);
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        sub_a  = {{(SUB_W-29){1'b0}}, rem_sh};
        sub_b  = {{(SUB_W-28){1'b0}}, root_q, 2'b01};
        rem_d  = sub_res.ge ? sub_res.diff[26:0] : rem_sh[26:0];
        root_d = root_step;
        prod_d = {prod_q[57:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          ias_d   = (root_step[25:24] != 2'b00) ? 24'hFF_FFFF : root_step[23:0];
          state_d = ST_PMID;
        end
      end
      ST_PMID: begin
        pmid_d = pmid_c;
        den_d  = den_c;
        if (den_c == '0) begin
          gain_d  = '0;
          state_d = ST_MUL_E;
        end else begin
          gain_d  = {24'd0, meas_noise_q == '0};
          r_d     = (meas_noise_q == '0) ? 33'd0 : {1'b0, pmid_c};
          cnt_d   = CNT_W'(DIV_STEPS - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        sub_a  = {r_q, 1'b0};
        sub_b  = {1'b0, den_q};
        r_d    = sub_res.ge ? sub_res.diff[32:0] : r_q[32:0] << 1;
        gain_d = {gain_q[23:0], sub_res.ge};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_MUL_E;
        end
      end
      ST_MUL_E: begin
        mul_a   = {8'd0, est_q};
        mul_b   = {3'd0, keep};
        prod_d  = mul_p;
        state_d = ST_MUL_G;
      end
      ST_MUL_G: begin
        acc_d   = prod_q[47:0];
        mul_a   = {8'd0, ias_q};
        mul_b   = {3'd0, gain_q};
        prod_d  = mul_p;
        state_d = ST_MUL_P;
      end
      ST_MUL_P: begin
        est_d   = est_sum[47:24];
        mul_a   = pmid_q;
        mul_b   = {3'd0, keep};
        prod_d  = mul_p;
        state_d = ST_COV;
      end
      ST_COV: begin
        cov_d   = cov_sum[55:24];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      offset_q <= '0;
      est_q    <= '0;
      cov_q    <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      offset_q <= offset_d;
      est_q    <= est_d;
      cov_q    <= cov_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ias_q   <= ias_d;
    below_q <= below_d;
    dp_q    <= dp_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    root_q  <= root_d;
    rem_q   <= rem_d;
    r_q     <= r_d;
    pmid_q  <= pmid_d;
    den_q   <= den_d;
    gain_q  <= gain_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise_q <= PROC_NOISE_RST;
      meas_noise_q <= MEAS_NOISE_RST;
      two_dens_q   <= TWO_DENS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PROC_NOISE: proc_noise_q <= cfg_data_i;
        CFG_MEAS_NOISE: meas_noise_q <= cfg_data_i;
        CFG_TWO_DENS:   two_dens_q   <= cfg_data_i[27:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {offset_q, est_q, ias_q};
  assign m_axis_tuser  = below_q;

  `ASSERT_CLK(a_one_side, !(s_axis_tready && m_axis_tvalid), "input and output both open")
  `ASSERT_IMP(a_clamp_val, m_axis_tvalid && m_axis_tuser[0],
              m_axis_tdata[23:0] == CLAMP_SPEED, "clamped item lacks fixed speed")
  `ASSERT_IMP(a_cal_fast, s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_MEASURE),
              ##1 m_axis_tvalid && (m_axis_tdata[23:0] == '0), "calibrate result late or nonzero")

endmodule

[verif/airspeed_from_diff_pressure_kalman_unit_tb.sv]
// Testbench: airspeed Kalman unit against a built-in predictor, random stream stalls.
`timescale 1ns / 1ps
module airspeed_from_diff_pressure_kalman_unit_tb
  import aspd_pkg::*;
();

  localparam logic [1:0]      REQ_IGNORED     = 2'd3;
  localparam longint unsigned ONE_Q24         = 64'd16777216;
  localparam longint unsigned HALF_LSB_Q24    = 64'd8388608;
  localparam int              HOLD_CYCLES     = 400;
  localparam int              DRAIN_CYCLES    = 64;
  localparam int              CYCLE_LIMIT     = 1_000_000;
  localparam int              ITEMS_PER_PHASE = 114;
  localparam int              PHASES          = 6;

  typedef struct {
    logic        [23:0] ias_unfiltered;
    logic        [23:0] ias_filtered;
    logic signed [23:0] offset_now;
    logic               below_zero;
  } airspeed_reading_t;

  class kalman_airspeed_tracker;
    logic        [31:0] proc_noise_q = PROC_NOISE_RST;
    logic        [31:0] meas_noise_q = MEAS_NOISE_RST;
    logic        [27:0] two_dens_q   = TWO_DENS_RST;
    logic signed [23:0] offset_q     = '0;
    logic        [23:0] estimate_q   = '0;
    logic        [31:0] covar_q      = '0;
    airspeed_reading_t  pending_readings[$];
    int                 mismatches   = 0;

    function void set_register(cfg_idx_e idx, logic [31:0] value);
      case (idx)
        CFG_PROC_NOISE: proc_noise_q = value;
        CFG_MEAS_NOISE: meas_noise_q = value;
        CFG_TWO_DENS:   two_dens_q   = value[27:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 27; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function airspeed_reading_t predict_reading(logic [1:0] req, logic signed [23:0] raw);
      airspeed_reading_t r;
      longint            dp;
      longint            sum;
      longint unsigned   root;
      longint unsigned   p_mid;
      longint unsigned   den;
      longint unsigned   gain;
      longint unsigned   keep;
      longint unsigned   acc;
      r.ias_unfiltered = '0;
      r.below_zero     = 1'b0;
      if (req == REQ_MEASURE) begin
        dp = longint'(raw) - longint'(offset_q);
        if (dp < 0) begin
          r.below_zero     = 1'b1;
          r.ias_unfiltered = CLAMP_SPEED;
        end else if (dp > 0) begin
          root = sqrt_floor(64'(dp) * 64'(two_dens_q));
          r.ias_unfiltered = (root > 64'hFFFFFF) ? 24'hFFFFFF : root[23:0];
        end
        p_mid = 64'(covar_q) + 64'(proc_noise_q);
        if (p_mid > 64'hFFFF_FFFF) p_mid = 64'hFFFF_FFFF;
        den  = p_mid + 64'(meas_noise_q);
        gain = (den == 0) ? 64'd0 : (p_mid << 24) / den;
        keep = ONE_Q24 - gain;
        acc = 64'(estimate_q) * keep + 64'(r.ias_unfiltered) * gain + HALF_LSB_Q24;
        estimate_q = acc[47:24];
        acc = keep * p_mid + HALF_LSB_Q24;
        covar_q = acc[55:24];
      end else if (req == REQ_CAL_INIT) begin
        offset_q = raw;
      end else if (req == REQ_CAL_NEXT) begin
        sum = longint'(offset_q) + longint'(raw);
        sum = sum >>> 1;
        offset_q = sum[23:0];
      end
      r.ias_filtered = estimate_q;
      r.offset_now   = offset_q;
      return r;
    endfunction

    function void take_sample(logic [1:0] req, logic signed [23:0] raw);
      pending_readings.push_back(predict_reading(req, raw));
    endfunction

    function int outstanding();
      return pending_readings.size();
    endfunction

    function void compare_reading(logic [71:0] data, logic [0:0] user);
      airspeed_reading_t want;
      if (pending_readings.size() == 0) begin
        $error("result with no item pending: tdata %h tuser %h", data, user);
        mismatches++;
        return;
      end
      want = pending_readings.pop_front();
      if (data[23:0] !== want.ias_unfiltered) begin
        $error("ias_unfiltered: expected %0d, got %0d", want.ias_unfiltered, data[23:0]);
        mismatches++;
      end
      if (data[47:24] !== want.ias_filtered) begin
        $error("ias_filtered: expected %0d, got %0d", want.ias_filtered, data[47:24]);
        mismatches++;
      end
      if (data[71:48] !== want.offset_now) begin
        $error("offset_now: expected %0d, got %0d", want.offset_now, $signed(data[71:48]));
        mismatches++;
      end
      if (user[0] !== want.below_zero) begin
        $error("below_zero: expected %0d, got %0d", want.below_zero, user[0]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [23:0] raw_pressure
  logic [1:0]  s_axis_tuser;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [23:0] ias_unfiltered, [47:24] ias_filtered, [71:48] offset_now
  logic [0:0]  m_axis_tuser;   // [0] below_zero
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  kalman_airspeed_tracker tracker;
  bit                     long_hold_req = 1'b0;
  int                     send_quiet    = 0;
  int                     sink_quiet    = 0;
  int                     cycle_count   = 0;

  airspeed_from_diff_pressure_kalman_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("airspeed_from_diff_pressure_kalman_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic send_sample(logic [1:0] req, logic signed [23:0] raw);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_sample(req, raw);
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_noise_setting(logic [31:0] q, logic [31:0] r, logic [27:0] dens);
    wait_drained();
    write_register(CFG_PROC_NOISE, q);
    write_register(CFG_MEAS_NOISE, r);
    write_register(CFG_TWO_DENS, {4'b0, dens});
  endtask

  function automatic logic signed [23:0] pick_zero_point();
    if ($urandom_range(0, 4) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 8000)) - 4000);
  endfunction

  function automatic logic signed [23:0] pick_measure(logic signed [23:0] base);
    case ($urandom_range(0, 9))
      0:       return 24'($urandom);
      1:       return 24'h7FFFFF;
      2:       return 24'h800000;
      3:       return 24'(int'(base) - int'($urandom_range(1, 3000)));
      4:       return base;
      5, 6:    return 24'(int'(base) + int'($urandom_range(1, 5000)));
      7:       return 24'(int'(base) + int'($urandom_range(1, 400000)));
      default: return 24'(int'(base) + int'($urandom_range(1, 8388607)));
    endcase
  endfunction

  task automatic run_random(int count, int hold_at, int pause_at);
    int                 sent;
    int                 cal_left;
    int                 choice;
    logic [1:0]         req;
    logic signed [23:0] raw;
    logic signed [23:0] zero_point;
    sent       = 0;
    cal_left   = 0;
    zero_point = '0;
    while (sent < count) begin
      if (sent == hold_at) begin
        long_hold_req = 1'b1;
        hold_at       = -1;
      end
      if (sent == pause_at) begin
        wait_drained();
        pause_at = -1;
      end
      choice = $urandom_range(0, 99);
      if (cal_left > 0) begin
        req = REQ_CAL_NEXT;
        raw = 24'(int'(zero_point) + int'($urandom_range(0, 128)) - 64);
        cal_left--;
      end else if (choice < 6) begin
        req        = REQ_CAL_INIT;
        zero_point = pick_zero_point();
        raw        = zero_point;
        cal_left   = $urandom_range(0, 5);
      end else if (choice < 90) begin
        req = REQ_MEASURE;
        raw = pick_measure(zero_point);
      end else if (choice < 96) begin
        req = 2'($urandom_range(0, 3));
        raw = 24'($urandom);
      end else begin
        req = REQ_IGNORED;
        raw = 24'($urandom);
      end
      send_sample(req, raw);
      if (req != REQ_IGNORED) sent++;
    end
  endtask

  initial begin
    int wait_cycles;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        wait_cycles   = HOLD_CYCLES;
      end else begin
        wait_cycles = draw_gap(sink_quiet);
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.compare_reading(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    tracker = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_MEASURE;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_PROC_NOISE;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(REQ_MEASURE, 24'h000000);
    send_sample(REQ_MEASURE, 24'h7FFFFF);
    send_sample(REQ_MEASURE, 24'h800000);
    send_sample(REQ_MEASURE, 24'h000001);
    send_sample(REQ_MEASURE, 24'hFFFFFF);
    send_sample(REQ_CAL_INIT, 24'h7FFFFF);
    send_sample(REQ_MEASURE, 24'h800000);
    send_sample(REQ_CAL_NEXT, 24'h800000);
    send_sample(REQ_CAL_NEXT, 24'h800000);
    send_sample(REQ_CAL_INIT, 24'h800000);
    send_sample(REQ_MEASURE, 24'h7FFFFF);
    send_sample(REQ_CAL_NEXT, 24'h7FFFFF);
    send_sample(REQ_IGNORED, 24'h003039);
    send_sample(REQ_CAL_INIT, 24'h000003);
    send_sample(REQ_CAL_NEXT, 24'hFFFFFC);
    send_sample(REQ_MEASURE, 24'hFFFFFF);
    send_sample(REQ_CAL_INIT, 24'h000000);
    send_sample(REQ_MEASURE, 24'h000100);
    send_sample(REQ_MEASURE, 24'h006400);
    send_sample(REQ_IGNORED, 24'hFFFFFF);
    send_sample(REQ_MEASURE, 24'h006400);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_noise_setting(32'h0, 32'h0, 28'd1);
        1: apply_noise_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 28'hFFF_FFFF);
        2: apply_noise_setting(32'h0, 32'hFFFF_FFFF, 28'($urandom_range(1, 28'hFFF_FFFF)));
        3: apply_noise_setting(32'hFFFF_FFFF, 32'h0, 28'($urandom_range(1, 28'hFFF_FFFF)));
        4: apply_noise_setting($urandom, $urandom, 28'($urandom_range(1, 28'hFFF_FFFF)));
        default: apply_noise_setting(PROC_NOISE_RST, MEAS_NOISE_RST, TWO_DENS_RST);
      endcase
      run_random(ITEMS_PER_PHASE, (p == 1) ? 40 : -1, (p == 3) ? 50 : -1);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("airspeed_from_diff_pressure_kalman_unit_tb OK");
    end else begin
      $display("airspeed_from_diff_pressure_kalman_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/aspd_pkg.sv
design/aspd_sub_unit.sv
design/airspeed_from_diff_pressure_kalman_unit.sv
verif/airspeed_from_diff_pressure_kalman_unit_tb.sv
